[design/assert_macros.svh]
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[design/ilt_pkg.sv]
// package for the indexed list table: sizes, codes and word types
package ilt_pkg;

   localparam int CAPACITY       = 16;
   localparam int DATA_WIDTH     = 32;
   localparam int POS_WIDTH      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_WIDTH    = $clog2(CAPACITY + 1);
   localparam int INDEX_WIDTH    = 5;
   localparam int POSITION_WIDTH = 4;
   localparam int ENTRY_CNT_WIDTH = 5;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_SEARCH = 2'd1,
      ACT_GET    = 2'd2,
      ACT_SET    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      action_type                    action;
      logic [INDEX_WIDTH-1:0]        index;
      logic signed [DATA_WIDTH-1:0]  value;
   } req_word_type;

   typedef struct packed {
      status_type                    status;
      logic                          found;
      logic [POSITION_WIDTH-1:0]     position;
      logic signed [DATA_WIDTH-1:0]  data;
      logic [ENTRY_CNT_WIDTH-1:0]    entry_count;
      logic                          empty_res;
   } rsp_word_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic                          shift;
      logic                          write;
      logic [INDEX_WIDTH-1:0]        index;
      logic signed [DATA_WIDTH-1:0]  value;
   } cell_ctrl_type;

endpackage

[design/ilt_cell.sv]
// one storage cell of the list: holds an entry, shifts up or loads, compares
module ilt_cell (
   input  logic                                 clock,
   input  ilt_pkg::cell_ctrl_type               ctrl,
   input  logic [ilt_pkg::POS_WIDTH-1:0]        cell_pos,
   input  logic signed [ilt_pkg::DATA_WIDTH-1:0] shift_data,
   output logic signed [ilt_pkg::DATA_WIDTH-1:0] data,
   output logic                                 match
);

   logic signed [ilt_pkg::DATA_WIDTH-1:0] data_ff;
   logic signed [ilt_pkg::DATA_WIDTH-1:0] data_in;
   logic [ilt_pkg::INDEX_WIDTH-1:0]       pos_ext;
   logic                                  at_index;
   logic                                  above_index;

   assign pos_ext     = ilt_pkg::INDEX_WIDTH'(cell_pos);
   assign at_index    = (pos_ext == ctrl.index);
   assign above_index = (pos_ext > ctrl.index);

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift && above_index) begin
         data_in = shift_data;
      end
      if ((ctrl.shift || ctrl.write) && at_index) begin
         data_in = ctrl.value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = (data_ff == ctrl.value);

endmodule

[design/ilt_chain.sv]
// row of list cells, each handing its entry to the next one up on insert
module ilt_chain (
   input  logic                                  clock,
   input  ilt_pkg::cell_ctrl_type                ctrl,
   output logic signed [ilt_pkg::DATA_WIDTH-1:0] entry_data [ilt_pkg::CAPACITY],
   output logic [ilt_pkg::CAPACITY-1:0]          match
);

   for (genvar i = 0; i < ilt_pkg::CAPACITY; i++) begin : g_cell
      logic signed [ilt_pkg::DATA_WIDTH-1:0] left_data;

      if (i == 0) begin : g_first
         assign left_data = ctrl.value;
      end else begin : g_rest
         assign left_data = entry_data[i-1];
      end

      ilt_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_pos   (ilt_pkg::POS_WIDTH'(i)),
         .shift_data (left_data),
         .data       (entry_data[i]),
         .match      (match[i])
      );
   end

endmodule

[design/indexed_list_table.sv]
// indexed list table top level: command decode, entry count and result register
//
//  channel  ports                      handshake
//  request  start, busy, req_word      taken when start is high and busy low
//  result   rsp_valid, rsp_word        one-cycle strobe, one word per request
//
// every request is taken as soon as start is high; busy stays low, so a request can follow
// in the very next cycle
// the result word appears on the cycle after the request is taken
// insert shifts the row of cells in the same edge; search compares every cell
// in parallel and picks the lowest hit through a priority encoder
// synchronous reset clears the entry count and the result strobe only
// the receiver cannot stall, so nothing is ever held back
`include "assert_macros.svh"

module indexed_list_table (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ilt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output ilt_pkg::rsp_word_type rsp_word
);

   logic [ilt_pkg::COUNT_WIDTH-1:0]       count_ff;
   logic [ilt_pkg::COUNT_WIDTH-1:0]       count_in;
   logic                                  rsp_valid_ff;
   ilt_pkg::rsp_word_type                 rsp_word_ff;
   ilt_pkg::rsp_word_type                 rsp_word_in;
   ilt_pkg::cell_ctrl_type                ctrl;
   logic signed [ilt_pkg::DATA_WIDTH-1:0] entry_data [ilt_pkg::CAPACITY];
   logic [ilt_pkg::CAPACITY-1:0]          match;
   logic [ilt_pkg::CAPACITY-1:0]          hits;
   logic                                  accept;
   logic [ilt_pkg::COUNT_WIDTH-1:0]       idx_ext;
   logic                                  idx_in_list;
   logic                                  idx_le_count;
   logic                                  is_full;
   logic                                  any_hit;
   logic [ilt_pkg::POS_WIDTH-1:0]         hit_pos;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign idx_ext      = ilt_pkg::COUNT_WIDTH'(req_word.index);
   assign idx_in_list  = (req_word.index < ilt_pkg::INDEX_WIDTH'(count_ff))
                         && (idx_ext == ilt_pkg::COUNT_WIDTH'(req_word.index));
   assign idx_le_count = (req_word.index <= ilt_pkg::INDEX_WIDTH'(count_ff))
                         && (idx_ext == ilt_pkg::COUNT_WIDTH'(req_word.index));
   assign is_full      = (count_ff == ilt_pkg::COUNT_WIDTH'(ilt_pkg::CAPACITY));

   always_comb begin
      ctrl.shift = accept && (req_word.action == ilt_pkg::ACT_INSERT)
                   && idx_le_count && !is_full;
      ctrl.write = accept && (req_word.action == ilt_pkg::ACT_SET) && idx_in_list;
      ctrl.index = req_word.index;
      ctrl.value = req_word.value;
   end

   ilt_chain u_chain (
      .clock      (clock),
      .ctrl       (ctrl),
      .entry_data (entry_data),
      .match      (match)
   );

   // only cells below the count take part in a search
   always_comb begin
      for (int i = 0; i < ilt_pkg::CAPACITY; i++) begin
         hits[i] = match[i] && (ilt_pkg::COUNT_WIDTH'(i) < count_ff);
      end
   end

   // lowest hit wins
   always_comb begin
      hit_pos = '0;
      for (int i = ilt_pkg::CAPACITY - 1; i >= 0; i--) begin
         if (hits[i]) begin
            hit_pos = ilt_pkg::POS_WIDTH'(i);
         end
      end
   end

   assign any_hit = |hits;

   always_comb begin
      count_in = count_ff;
      if (ctrl.shift) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_word_in             = '0;
      rsp_word_in.status      = ilt_pkg::STATUS_OK;
      case (req_word.action)
         ilt_pkg::ACT_INSERT: begin
            if (!idx_le_count) begin
               rsp_word_in.status = ilt_pkg::STATUS_BAD_INDEX;
            end else if (is_full) begin
               rsp_word_in.status = ilt_pkg::STATUS_FULL;
            end
         end
         ilt_pkg::ACT_SEARCH: begin
            rsp_word_in.found = any_hit;
            if (any_hit) begin
               rsp_word_in.position = ilt_pkg::POSITION_WIDTH'(hit_pos);
            end
         end
         ilt_pkg::ACT_GET: begin
            if (!idx_in_list) begin
               rsp_word_in.status = ilt_pkg::STATUS_BAD_INDEX;
            end else begin
               rsp_word_in.data = entry_data[req_word.index[ilt_pkg::POS_WIDTH-1:0]];
            end
         end
         ilt_pkg::ACT_SET: begin
            if (!idx_in_list) begin
               rsp_word_in.status = ilt_pkg::STATUS_BAD_INDEX;
            end
         end
         default: begin
            rsp_word_in.status = ilt_pkg::STATUS_OK;
         end
      endcase
      rsp_word_in.entry_count = ilt_pkg::ENTRY_CNT_WIDTH'(count_in);
      rsp_word_in.empty_res   = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > ilt_pkg::COUNT_WIDTH'(ilt_pkg::CAPACITY), "entry count above capacity")
   `ASSERT_CLK(a_one_result, clock, reset, accept |=> rsp_valid, "request gave no result")
   `ASSERT_CLK(a_hit_in_list, clock, reset, (rsp_valid && rsp_word.found) |-> (rsp_word.status == ilt_pkg::STATUS_OK && ilt_pkg::ENTRY_CNT_WIDTH'(rsp_word.position) < rsp_word.entry_count), "search hit outside list")
   `ASSERT_CLK(a_insert_count, clock, reset, (accept && req_word.action == ilt_pkg::ACT_INSERT) |=> ((rsp_word.status == ilt_pkg::STATUS_OK) == (count_ff == $past(count_ff) + 1'b1)), "insert status and count disagree")

endmodule
